@@ sv/wuf_pkg.sv @@
// Shared types and constants for the weighted union-find unit.
`timescale 1ns / 1ps
`default_nettype none
package wuf_pkg;

    localparam int DEFAULT_MAX_ELEMENTS = 1024;
    localparam int RESET_ELEMENT_COUNT  = 1024;
    localparam int IDX_W                = 10;
    localparam int CNT_W                = 11;
    localparam int QUEUE_DEPTH          = 2;
    localparam int APB_ADDR_W           = 3;
    localparam int APB_DATA_W           = 32;

    localparam logic KIND_UNION = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [APB_ADDR_W-3:0] REG_ELEMENT_COUNT = '0;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic kind;
        logic bad;
        idx_t first;
        idx_t second;
    } wuf_item_t;

endpackage
`default_nettype wire

@@ sv/wuf_queue.sv @@
// Small FIFO that decouples the item front end from the execution engine.
`timescale 1ns / 1ps
`default_nettype none
module wuf_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wuf_pkg::wuf_item_t push_item,
    input  wire logic               pop,
    output logic                    full,
    output logic                    not_empty,
    output wuf_pkg::wuf_item_t      head
);
    import wuf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    wuf_item_t            entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ sv/wuf_front.sv @@
// Front end: accepts item beats, range-checks indices and queues them.
`timescale 1ns / 1ps
`default_nettype none
module wuf_front
(
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire wuf_pkg::idx_t      first_element,
    input  wire wuf_pkg::idx_t      second_element,
    input  wire wuf_pkg::cnt_t      element_count,
    input  wire logic               busy,
    input  wire logic               q_full,
    output logic                    q_push,
    output wuf_pkg::wuf_item_t      q_item
);
    import wuf_pkg::*;

    logic first_bad;
    logic second_bad;

    // No beats taken while the tables are being reinitialized.
    assign in_ready   = !q_full && !busy;
    assign q_push     = in_valid && in_ready;
    assign first_bad  = (CNT_W'(first_element) >= element_count);
    assign second_bad = (CNT_W'(second_element) >= element_count);

    always_comb
    begin
        q_item.kind   = kind;
        q_item.bad    = first_bad || second_bad;
        q_item.first  = first_element;
        q_item.second = second_element;
    end

endmodule
`default_nettype wire

@@ sv/wuf_back.sv @@
// Execution engine: table init, root walks, weighted link and result register.
`timescale 1ns / 1ps
`default_nettype none
module wuf_back
#(
    parameter int MAX_ELEMENTS = wuf_pkg::DEFAULT_MAX_ELEMENTS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               init_start,
    input  wire wuf_pkg::cnt_t      element_count,
    input  wire logic               q_valid,
    input  wire wuf_pkg::wuf_item_t q_item,
    output logic                    q_pop,
    output logic                    busy,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    same_set,
    output wuf_pkg::cnt_t           component_count,
    output logic                    out_of_range
);
    import wuf_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);

    typedef logic [AW-1:0] addr_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_LINK,
        S_DONE
    } state_t;

    addr_t  par_mem  [MAX_ELEMENTS];
    cnt_t   size_mem [MAX_ELEMENTS];

    state_t state_reg;
    cnt_t   clr_reg;
    addr_t  node_reg;
    addr_t  ra_reg;
    cnt_t   sa_reg;
    idx_t   second_reg;
    logic   kind_reg;
    logic   bad_reg;
    logic   same_reg;
    cnt_t   components_reg;
    logic   out_valid_reg;
    logic   same_set_reg;
    cnt_t   component_count_reg;
    logic   out_of_range_reg;

    addr_t  par_raddr;
    addr_t  par_rdata;
    logic   par_we;
    addr_t  par_waddr;
    addr_t  par_wdata;
    logic   size_re;
    addr_t  size_raddr;
    cnt_t   size_rdata;
    logic   size_we;
    addr_t  size_waddr;
    cnt_t   size_wdata;
    logic   at_root;
    cnt_t   size_sum;

    assign at_root  = (par_rdata == node_reg);
    assign size_sum = sa_reg + size_rdata;
    assign busy     = (state_reg == S_CLEAR);

    assign out_valid       = out_valid_reg;
    assign same_set        = same_set_reg;
    assign component_count = component_count_reg;
    assign out_of_range    = out_of_range_reg;

    always_comb
    begin
        q_pop      = 1'b0;
        par_raddr  = node_reg;
        par_we     = 1'b0;
        par_waddr  = node_reg;
        par_wdata  = ra_reg;
        size_re    = 1'b0;
        size_raddr = node_reg;
        size_we    = 1'b0;
        size_waddr = node_reg;
        size_wdata = size_sum;
        case (state_reg)
            S_CLEAR:
            begin
                par_we     = 1'b1;
                par_waddr  = AW'(clr_reg);
                par_wdata  = AW'(clr_reg);
                size_we    = 1'b1;
                size_waddr = AW'(clr_reg);
                size_wdata = CNT_W'(1);
            end
            S_IDLE:
            begin
                if (q_valid && !init_start)
                begin
                    q_pop     = 1'b1;
                    par_raddr = AW'(q_item.first);
                end
            end
            S_WALK_A:
            begin
                if (at_root)
                begin
                    par_raddr = AW'(second_reg);
                    size_re   = 1'b1;
                end
                else
                begin
                    par_raddr = par_rdata;
                end
            end
            S_WALK_B:
            begin
                if (at_root)
                begin
                    size_re = 1'b1;
                end
                else
                begin
                    par_raddr = par_rdata;
                end
            end
            S_LINK:
            begin
                par_we  = 1'b1;
                size_we = 1'b1;
                // smaller set goes under the larger; ties hang b's root under a's
                if (sa_reg < size_rdata)
                begin
                    par_waddr  = ra_reg;
                    par_wdata  = node_reg;
                    size_waddr = node_reg;
                end
                else
                begin
                    par_waddr  = node_reg;
                    par_wdata  = ra_reg;
                    size_waddr = ra_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        par_rdata <= par_mem[par_raddr];
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (size_re)
        begin
            size_rdata <= size_mem[size_raddr];
        end
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_CLEAR;
            clr_reg             <= '0;
            components_reg      <= '0;
            out_valid_reg       <= 1'b0;
            node_reg            <= '0;
            ra_reg              <= '0;
            sa_reg              <= '0;
            second_reg          <= '0;
            kind_reg            <= KIND_UNION;
            bad_reg             <= 1'b0;
            same_reg            <= 1'b0;
            same_set_reg        <= 1'b0;
            component_count_reg <= '0;
            out_of_range_reg    <= 1'b0;
        end
        else
        begin
            // a result loaded in S_DONE takes the register over from here
            if (out_valid_reg && out_ready && (init_start || state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            if (init_start)
            begin
                state_reg <= S_CLEAR;
                clr_reg   <= '0;
            end
            else
            begin
                case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == element_count - 1'b1)
                        begin
                            components_reg <= element_count;
                            state_reg      <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (q_valid)
                        begin
                            kind_reg   <= q_item.kind;
                            bad_reg    <= q_item.bad;
                            second_reg <= q_item.second;
                            node_reg   <= AW'(q_item.first);
                            same_reg   <= 1'b0;
                            state_reg  <= q_item.bad ? S_DONE : S_WALK_A;
                        end
                    end
                    S_WALK_A:
                    begin
                        if (at_root)
                        begin
                            ra_reg    <= node_reg;
                            node_reg  <= AW'(second_reg);
                            state_reg <= S_WALK_B;
                        end
                        else
                        begin
                            node_reg <= par_rdata;
                        end
                    end
                    S_WALK_B:
                    begin
                        if (at_root)
                        begin
                            sa_reg <= size_rdata;
                            if (node_reg == ra_reg)
                            begin
                                same_reg  <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            else if (kind_reg == KIND_QUERY)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_LINK;
                            end
                        end
                        else
                        begin
                            node_reg <= par_rdata;
                        end
                    end
                    S_LINK:
                    begin
                        if (components_reg != '0)
                        begin
                            components_reg <= components_reg - 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                    S_DONE:
                    begin
                        if (!out_valid_reg || out_ready)
                        begin
                            out_valid_reg       <= 1'b1;
                            same_set_reg        <= same_reg;
                            component_count_reg <= components_reg;
                            out_of_range_reg    <= bad_reg;
                            state_reg           <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/weighted_union_find_unit.sv @@
// Top level of the weighted quick-union disjoint-set engine.
// Items with in-range indices walk to both roots, and a union of two sets then links them;
//   out-of-range items skip the walks. Root depth is at most log2(element_count).
// The engine takes one item at a time, the next only after the last is done, set by the serial
//   parent walk (one read port, one link per cycle); a two-entry queue takes beats meanwhile.
// Reset starts a table init pass with in_ready low; a write to the element count starts one too.
`timescale 1ns / 1ps
`default_nettype none
module weighted_union_find_unit
#(
    parameter int MAX_ELEMENTS = wuf_pkg::DEFAULT_MAX_ELEMENTS
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [wuf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [wuf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [wuf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             kind,
    input  wire wuf_pkg::idx_t                    first_element,
    input  wire wuf_pkg::idx_t                    second_element,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  same_set,
    output wuf_pkg::cnt_t                         component_count,
    output logic                                  out_of_range
);
    import wuf_pkg::*;

    localparam cnt_t RESET_COUNT =
        CNT_W'((MAX_ELEMENTS < RESET_ELEMENT_COUNT) ? MAX_ELEMENTS : RESET_ELEMENT_COUNT);

    cnt_t       element_count_reg;
    logic       init_reg;
    logic       cfg_write;
    cnt_t       wr_count;
    cnt_t       wr_clamped;
    logic       back_busy;
    logic       busy;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_not_empty;
    wuf_item_t  q_in;
    wuf_item_t  q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_ELEMENT_COUNT);
    assign wr_count  = pwdata[CNT_W-1:0];
    assign busy      = init_reg || back_busy;

    always_comb
    begin
        if (wr_count == '0)
        begin
            wr_clamped = CNT_W'(1);
        end
        else if (int'(wr_count) > MAX_ELEMENTS)
        begin
            wr_clamped = CNT_W'(MAX_ELEMENTS);
        end
        else
        begin
            wr_clamped = wr_count;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_ELEMENT_COUNT)
        begin
            prdata = APB_DATA_W'(element_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= RESET_COUNT;
            init_reg          <= 1'b0;
        end
        else
        begin
            init_reg <= cfg_write;
            if (cfg_write)
            begin
                element_count_reg <= wr_clamped;
            end
        end
    end

    wuf_front u_front
    (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .first_element  (first_element),
        .second_element (second_element),
        .element_count  (element_count_reg),
        .busy           (busy),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_in)
    );

    wuf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    wuf_back
    #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    )
    u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .init_start      (init_reg),
        .element_count   (element_count_reg),
        .q_valid         (q_not_empty),
        .q_item          (q_head),
        .q_pop           (q_pop),
        .busy            (back_busy),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .same_set        (same_set),
        .component_count (component_count),
        .out_of_range    (out_of_range)
    );

endmodule
`default_nettype wire
